// ===== sv/mbrtu_pkg.sv =====
package mbrtu_pkg;

  // CRC-16 as used on Modbus RTU lines: reflected polynomial, all-ones start.
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  // Number of frame bytes covered by the CRC, and the frame length.
  localparam int unsigned CRC_BODY  = 6;
  localparam int unsigned FRAME_LEN = 8;

  // Item operation codes.
  typedef enum logic {
    FUNC_BUILD = 1'b0,
    FUNC_RECV  = 1'b1
  } func_t;

  // Result kinds.
  typedef enum logic {
    KIND_TX = 1'b0,
    KIND_RX = 1'b1
  } kind_t;

  // Positions within a frame.
  localparam logic [2:0] POS_CRC_LO = 3'd6;
  localparam logic [2:0] POS_CRC_HI = 3'd7;

  // Advances a CRC over one byte, one polynomial step per bit.
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// ===== sv/modbus_rtu_frame_codec.sv =====
// Channel  Direction  Handshake          Payload
// in_      input      in_valid/in_stall  func, tx_address, tx_function, tx_register,
//                                        tx_data, rx_byte
// out_     output     out_valid/out_stall kind, tx_byte, last, rx_address, rx_function,
//                                        rx_register, rx_data, crc_ok
//
// A receive transaction carries one frame byte; a build transaction yields eight frame
// bytes from the byte sequencer into the single result register, one per cycle when unstalled.
// The transmit CRC is advanced by one byte in each of the first six sequencer steps.
// Reset (rst_n, synchronous, active low) clears the item, sequencer, output valid,
// receive count and receive CRC; no clearing pass is needed.
// A stall on the result channel holds the sequencer; the input register still takes
// the next transaction as soon as the held one has finished its last step.
module modbus_rtu_frame_codec
  import mbrtu_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_func,
  input  logic [7:0]  in_tx_address,
  input  logic [7:0]  in_tx_function,
  input  logic [15:0] in_tx_register,
  input  logic [15:0] in_tx_data,
  input  logic [7:0]  in_rx_byte,

  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_kind,
  output logic [7:0]  out_tx_byte,
  output logic        out_last,
  output logic [7:0]  out_rx_address,
  output logic [7:0]  out_rx_function,
  output logic [15:0] out_rx_register,
  output logic [15:0] out_rx_data,
  output logic        out_crc_ok
);

  // Held input transaction.
  logic        item_vld_r;
  func_t       item_func_r;
  logic [7:0]  item_addr_r;
  logic [7:0]  item_fn_r;
  logic [15:0] item_reg_r;
  logic [15:0] item_dat_r;
  logic [7:0]  item_byte_r;

  // Transmit sequencer.
  logic [2:0]  seq_r;
  logic [15:0] tx_crc_r;

  // Receive state.
  logic [2:0]  rx_count_r;
  logic [15:0] rx_crc_r;
  logic [7:0]  rx_bytes_r [7];

  // Result register.
  logic        out_valid_r;
  kind_t       out_kind_r;
  logic [7:0]  out_tx_byte_r;
  logic        out_last_r;
  logic [7:0]  out_rx_address_r;
  logic [7:0]  out_rx_function_r;
  logic [15:0] out_rx_register_r;
  logic [15:0] out_rx_data_r;
  logic        out_crc_ok_r;

  logic        out_free;
  logic        is_build;
  logic        rx_final;
  logic        step;
  logic        item_done;
  logic        in_accept;
  logic [7:0]  tx_sel;
  logic [15:0] tx_crc_cur;
  logic [15:0] rx_crc_upd;
  logic        rx_ok;

  // The result register can take a new result when empty or being emptied.
  assign out_free = !out_valid_r || !out_stall;
  assign is_build = (item_func_r == FUNC_BUILD);
  assign rx_final = (rx_count_r == POS_CRC_HI);

  // A step produces a result unless it is a receive byte before the last.
  assign step      = item_vld_r && ((!is_build && !rx_final) || out_free);
  assign item_done = step && (!is_build || (seq_r == POS_CRC_HI));
  assign in_stall  = item_vld_r && !item_done;
  assign in_accept = in_valid && !in_stall;

  // Frame byte for the current sequencer position.
  assign tx_crc_cur = (seq_r == 3'd0) ? CRC_INIT : tx_crc_r;
  always_comb begin
    case (seq_r)
      3'd0:       tx_sel = item_addr_r;
      3'd1:       tx_sel = item_fn_r;
      3'd2:       tx_sel = item_reg_r[15:8];
      3'd3:       tx_sel = item_reg_r[7:0];
      3'd4:       tx_sel = item_dat_r[15:8];
      3'd5:       tx_sel = item_dat_r[7:0];
      POS_CRC_LO: tx_sel = tx_crc_r[7:0];
      default:    tx_sel = tx_crc_r[15:8];
    endcase
  end

  // Receive CRC update and final check.
  assign rx_crc_upd = crc_byte(rx_crc_r, item_byte_r);
  assign rx_ok      = (rx_bytes_r[6] == rx_crc_r[7:0]) && (item_byte_r == rx_crc_r[15:8]);

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
    end else if (in_accept) begin
      item_vld_r <= 1'b1;
    end else if (item_done) begin
      item_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      item_func_r <= func_t'(in_func);
      item_addr_r <= in_tx_address;
      item_fn_r   <= in_tx_function;
      item_reg_r  <= in_tx_register;
      item_dat_r  <= in_tx_data;
      item_byte_r <= in_rx_byte;
    end
  end

  // Transmit sequencer and its running CRC.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_r <= 3'd0;
    end else if (step && is_build) begin
      seq_r <= seq_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (step && is_build && (seq_r < POS_CRC_LO)) begin
      tx_crc_r <= crc_byte(tx_crc_cur, tx_sel);
    end
  end

  // Receive count and CRC.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rx_count_r <= 3'd0;
      rx_crc_r   <= CRC_INIT;
    end else if (step && !is_build) begin
      if (rx_final) begin
        rx_count_r <= 3'd0;
        rx_crc_r   <= CRC_INIT;
      end else begin
        rx_count_r <= rx_count_r + 3'd1;
        if (rx_count_r < POS_CRC_LO) begin
          rx_crc_r <= rx_crc_upd;
        end
      end
    end
  end

  // Received byte store.
  always_ff @(posedge clk) begin
    if (step && !is_build && !rx_final) begin
      rx_bytes_r[rx_count_r] <= item_byte_r;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step && (is_build || rx_final)) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && is_build) begin
      out_kind_r        <= KIND_TX;
      out_tx_byte_r     <= tx_sel;
      out_last_r        <= (seq_r == POS_CRC_HI);
      out_rx_address_r  <= 8'h00;
      out_rx_function_r <= 8'h00;
      out_rx_register_r <= 16'h0000;
      out_rx_data_r     <= 16'h0000;
      out_crc_ok_r      <= 1'b0;
    end else if (step && rx_final) begin
      out_kind_r        <= KIND_RX;
      out_tx_byte_r     <= 8'h00;
      out_last_r        <= 1'b1;
      out_rx_address_r  <= rx_bytes_r[0];
      out_rx_function_r <= rx_bytes_r[1];
      out_rx_register_r <= {rx_bytes_r[2], rx_bytes_r[3]};
      out_rx_data_r     <= {rx_bytes_r[4], rx_bytes_r[5]};
      out_crc_ok_r      <= rx_ok;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_kind        = out_kind_r;
  assign out_tx_byte     = out_tx_byte_r;
  assign out_last        = out_last_r;
  assign out_rx_address  = out_rx_address_r;
  assign out_rx_function = out_rx_function_r;
  assign out_rx_register = out_rx_register_r;
  assign out_rx_data     = out_rx_data_r;
  assign out_crc_ok      = out_crc_ok_r;

endmodule
